// ===== rtl/pfrh_pkg.sv =====
// Package for the page frame run histogram block.
// Holds field widths, item class codes and shared types; depends on nothing.
package pfrh_pkg;

    localparam int ENTRY_W     = 64;
    localparam int FRAME_W     = 55;
    localparam int PRESENT_BIT = 63;
    localparam int RUN_W       = 10;
    localparam int TOTAL_W     = 40;
    localparam int BIN_OUT_W   = 32;
    localparam int CLASS_W     = 3;

    localparam logic [CLASS_W-1:0] CLS_ABSENT   = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_ZERO     = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_CONTIG   = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_BREAK    = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_BIN_READ = 3'd4;

    localparam logic REQ_CLASSIFY = 1'b0;
    localparam logic REQ_READ     = 1'b1;

    typedef enum logic {
        HS_CLEAR,
        HS_RUN
    } t_hist_state;

    typedef struct packed {
        logic valid;
        logic bump;
    } t_hist_op;

    typedef struct packed {
        logic [CLASS_W-1:0]   item_class;
        logic [RUN_W-1:0]     run_length;
        logic [BIN_OUT_W-1:0] bin_count;
        logic [TOTAL_W-1:0]   count_not_present;
        logic [TOTAL_W-1:0]   count_zero_frame;
        logic [TOTAL_W-1:0]   count_continue;
        logic [TOTAL_W-1:0]   count_break;
    } t_rsp;

endpackage

// ===== rtl/pfrh_if.sv =====
// Handshake channel interfaces for request and result words.
// Depends on pfrh_pkg for the field widths.
interface pfrh_in_if;
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic [pfrh_pkg::ENTRY_W-1:0]      entry;
    logic [pfrh_pkg::RUN_W-1:0]        bin_index;

    modport source (output valid, output req_type, output entry, output bin_index,
                    input ready);
    modport sink (input valid, input req_type, input entry, input bin_index,
                  output ready);
endinterface

interface pfrh_out_if;
    logic                              valid;
    logic                              ready;
    logic [pfrh_pkg::CLASS_W-1:0]      item_class;
    logic [pfrh_pkg::RUN_W-1:0]        run_length;
    logic [pfrh_pkg::BIN_OUT_W-1:0]    bin_count;
    logic [pfrh_pkg::TOTAL_W-1:0]      count_not_present;
    logic [pfrh_pkg::TOTAL_W-1:0]      count_zero_frame;
    logic [pfrh_pkg::TOTAL_W-1:0]      count_continue;
    logic [pfrh_pkg::TOTAL_W-1:0]      count_break;

    modport source (output valid, output item_class, output run_length, output bin_count,
                    output count_not_present, output count_zero_frame,
                    output count_continue, output count_break, input ready);
    modport sink (input valid, input item_class, input run_length, input bin_count,
                  input count_not_present, input count_zero_frame,
                  input count_continue, input count_break, output ready);
endinterface

// ===== rtl/pfrh_hist.sv =====
// Histogram bin memory with read-modify-write, write forwarding and a
// clearing pass after reset. Depends on pfrh_pkg.
module pfrh_hist #(
    parameter int HIST_DEPTH = 1024,
    parameter int BIN_WIDTH  = 32,
    parameter int AW         = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pfrh_pkg::t_hist_op     i_op,
    input  logic [AW-1:0]          i_addr,
    output logic                   o_ready,
    output logic [BIN_WIDTH-1:0]   o_data
);

    logic [BIN_WIDTH-1:0] r_mem [HIST_DEPTH];
    logic [BIN_WIDTH-1:0] r_rd_data;

    pfrh_pkg::t_hist_state r_state;
    pfrh_pkg::t_hist_state n_state;
    logic [AW-1:0]         r_clr_addr;
    logic                  clr_last;
    logic                  clr_we;

    logic                  r_s1_bump;
    logic [AW-1:0]         r_s1_addr;
    logic                  r_fw_valid;
    logic [AW-1:0]         r_fw_addr;
    logic [BIN_WIDTH-1:0]  r_fw_data;

    logic [BIN_WIDTH-1:0]  cur_data;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [BIN_WIDTH-1:0]  wr_data;

    assign clr_last = (r_clr_addr == AW'(HIST_DEPTH - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            pfrh_pkg::HS_CLEAR: begin
                if (clr_last) begin
                    n_state = pfrh_pkg::HS_RUN;
                end
            end
            pfrh_pkg::HS_RUN: begin
                n_state = pfrh_pkg::HS_RUN;
            end
            default: begin
                n_state = pfrh_pkg::HS_CLEAR;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            pfrh_pkg::HS_CLEAR: begin
                clr_we  = 1'b1;
                o_ready = 1'b0;
            end
            pfrh_pkg::HS_RUN: begin
                clr_we  = 1'b0;
                o_ready = 1'b1;
            end
            default: begin
                clr_we  = 1'b0;
                o_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pfrh_pkg::HS_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (clr_we) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // The word read this cycle misses the write made in the same cycle,
    // so that write is registered and used in its place.
    assign cur_data = (r_fw_valid && (r_fw_addr == r_s1_addr)) ? r_fw_data : r_rd_data;
    assign o_data   = cur_data;

    always_comb begin
        if (clr_we) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = r_s1_bump;
            wr_addr = r_s1_addr;
            wr_data = (cur_data == {BIN_WIDTH{1'b1}}) ? cur_data
                                                      : cur_data + BIN_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_addr];
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_bump  <= 1'b0;
            r_fw_valid <= 1'b0;
        end else begin
            r_s1_bump  <= i_op.valid & i_op.bump;
            r_fw_valid <= wr_en;
        end
        r_s1_addr <= i_addr;
        r_fw_addr <= wr_addr;
        r_fw_data <= wr_data;
    end

endmodule

// ===== rtl/page_frame_run_histogram_top.sv =====
// Page frame run histogram: classifies page-table entries, keeps four class
// totals and a histogram of run lengths, and answers bin reads.
// A result word is registered in the memory read stage, then queued, before it is offered.
// Throughput: one word per cycle while the result queue has room.
// Reset: synchronous; a clearing pass zeroes all HIST_DEPTH bins,
// and no request is accepted until it ends.
module page_frame_run_histogram_top #(
    parameter int HIST_DEPTH = 1024,
    parameter int BIN_WIDTH  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfrh_in_if.sink     i_in,
    pfrh_out_if.source  o_out
);

    localparam int AW      = $clog2(HIST_DEPTH);
    localparam int FIFO_N  = 4;
    localparam int PTR_W   = $clog2(FIFO_N);
    localparam int CNT_W   = PTR_W + 1;

    logic [pfrh_pkg::FRAME_W-1:0] r_last_frame;
    logic [pfrh_pkg::RUN_W-1:0]   r_run_count;
    logic [AW-1:0]                r_run_bin;
    logic [pfrh_pkg::TOTAL_W-1:0] r_cnt_absent;
    logic [pfrh_pkg::TOTAL_W-1:0] r_cnt_zero;
    logic [pfrh_pkg::TOTAL_W-1:0] r_cnt_contig;
    logic [pfrh_pkg::TOTAL_W-1:0] r_cnt_break;

    logic                         r_s1_valid;
    logic [pfrh_pkg::CLASS_W-1:0] r_s1_class;
    logic                         r_s1_hit;

    pfrh_pkg::t_rsp               r_fifo [FIFO_N];
    logic [PTR_W-1:0]             r_wr_ptr;
    logic [PTR_W-1:0]             r_rd_ptr;
    logic [CNT_W-1:0]             r_count;

    logic                         accept;
    logic                         pop;
    logic                         hist_ready;
    logic [BIN_WIDTH-1:0]         hist_data;
    logic [BIN_WIDTH+pfrh_pkg::BIN_OUT_W-1:0] bin_ext;
    pfrh_pkg::t_hist_op           hist_op;
    logic [AW-1:0]                hist_addr;

    logic                         present;
    logic [pfrh_pkg::FRAME_W-1:0] frame;
    logic                         contig;
    logic                         in_range;
    logic [pfrh_pkg::CLASS_W-1:0] cls;
    pfrh_pkg::t_rsp               push_word;

    assign present = i_in.entry[pfrh_pkg::PRESENT_BIT];
    assign frame   = i_in.entry[pfrh_pkg::FRAME_W-1:0];
    assign contig  = ({1'b0, frame} == ({1'b0, r_last_frame} + (pfrh_pkg::FRAME_W+1)'(1)));
    assign in_range = ({22'b0, i_in.bin_index} < 32'(HIST_DEPTH));

    always_comb begin
        if (i_in.req_type == pfrh_pkg::REQ_READ) begin
            cls = pfrh_pkg::CLS_BIN_READ;
        end else if (!present) begin
            cls = pfrh_pkg::CLS_ABSENT;
        end else if (frame == '0) begin
            cls = pfrh_pkg::CLS_ZERO;
        end else if (contig) begin
            cls = pfrh_pkg::CLS_CONTIG;
        end else begin
            cls = pfrh_pkg::CLS_BREAK;
        end
    end

    assign i_in.ready = hist_ready
                      && ((r_count + CNT_W'(r_s1_valid)) < CNT_W'(FIFO_N));
    assign accept     = i_in.valid && i_in.ready;

    assign hist_op.valid = accept;
    assign hist_op.bump  = (cls == pfrh_pkg::CLS_BREAK);
    assign hist_addr     = (i_in.req_type == pfrh_pkg::REQ_READ) ? AW'(i_in.bin_index)
                                                                 : r_run_bin;

    pfrh_hist #(
        .HIST_DEPTH (HIST_DEPTH),
        .BIN_WIDTH  (BIN_WIDTH),
        .AW         (AW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (hist_op),
        .i_addr  (hist_addr),
        .o_ready (hist_ready),
        .o_data  (hist_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_frame <= '0;
            r_run_count  <= '0;
            r_run_bin    <= '0;
            r_cnt_absent <= '0;
            r_cnt_zero   <= '0;
            r_cnt_contig <= '0;
            r_cnt_break  <= '0;
        end else if (accept) begin
            case (cls)
                pfrh_pkg::CLS_ABSENT: begin
                    if (r_cnt_absent != '1) begin
                        r_cnt_absent <= r_cnt_absent + pfrh_pkg::TOTAL_W'(1);
                    end
                    r_run_count  <= '0;
                    r_run_bin    <= '0;
                    r_last_frame <= '0;
                end
                pfrh_pkg::CLS_ZERO: begin
                    if (r_cnt_zero != '1) begin
                        r_cnt_zero <= r_cnt_zero + pfrh_pkg::TOTAL_W'(1);
                    end
                    r_run_count  <= '0;
                    r_run_bin    <= '0;
                    r_last_frame <= '0;
                end
                pfrh_pkg::CLS_CONTIG: begin
                    if (r_cnt_contig != '1) begin
                        r_cnt_contig <= r_cnt_contig + pfrh_pkg::TOTAL_W'(1);
                    end
                    r_run_count  <= r_run_count + pfrh_pkg::RUN_W'(1);
                    // The bin index follows the run counter modulo the depth,
                    // and restarts with it when the counter wraps.
                    if ((r_run_count == '1) || (r_run_bin == AW'(HIST_DEPTH - 1))) begin
                        r_run_bin <= '0;
                    end else begin
                        r_run_bin <= r_run_bin + AW'(1);
                    end
                    r_last_frame <= frame;
                end
                pfrh_pkg::CLS_BREAK: begin
                    if (r_cnt_break != '1) begin
                        r_cnt_break <= r_cnt_break + pfrh_pkg::TOTAL_W'(1);
                    end
                    r_run_count  <= '0;
                    r_run_bin    <= '0;
                    r_last_frame <= frame;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
        r_s1_class <= cls;
        r_s1_hit   <= (i_in.req_type == pfrh_pkg::REQ_READ) && in_range;
    end

    // The state registers already hold this word's totals while it sits in
    // the memory read stage.
    assign bin_ext = {{pfrh_pkg::BIN_OUT_W{1'b0}}, hist_data};

    always_comb begin
        push_word.item_class        = r_s1_class;
        push_word.run_length        = r_run_count;
        push_word.bin_count         = r_s1_hit ? bin_ext[pfrh_pkg::BIN_OUT_W-1:0] : '0;
        push_word.count_not_present = r_cnt_absent;
        push_word.count_zero_frame  = r_cnt_zero;
        push_word.count_continue    = r_cnt_contig;
        push_word.count_break       = r_cnt_break;
    end

    assign pop = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_fifo[r_wr_ptr] <= push_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (r_s1_valid) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(r_s1_valid) - CNT_W'(pop);
        end
    end

    assign o_out.valid             = (r_count != '0);
    assign o_out.item_class        = r_fifo[r_rd_ptr].item_class;
    assign o_out.run_length        = r_fifo[r_rd_ptr].run_length;
    assign o_out.bin_count         = r_fifo[r_rd_ptr].bin_count;
    assign o_out.count_not_present = r_fifo[r_rd_ptr].count_not_present;
    assign o_out.count_zero_frame  = r_fifo[r_rd_ptr].count_zero_frame;
    assign o_out.count_continue    = r_fifo[r_rd_ptr].count_continue;
    assign o_out.count_break       = r_fifo[r_rd_ptr].count_break;

`ifndef SYNTHESIS
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_N))
        else $error("result queue holds more words than it has entries");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_count != CNT_W'(FIFO_N)))
        else $error("word pushed into a full result queue");

    a_bin_follows_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run_count == '0) |-> (r_run_bin == '0))
        else $error("bin index out of step with the run counter");
`endif

endmodule
